FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl folder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next clock cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/xrslc_pkg.sv
// ---------------------------------------------------------------------------
// xrslc_pkg
// types and constants of the session lifecycle block
// ---------------------------------------------------------------------------
package xrslc_pkg;

    localparam int EVENT_QUEUE_DEPTH = 8;
    localparam int QIDX_W = $clog2(EVENT_QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(EVENT_QUEUE_DEPTH + 1);

    localparam int OP_W     = 3;
    localparam int STATE_W  = 3;
    localparam int TIME_W   = 62;
    localparam int PRED_W   = 63;
    localparam int PERIOD_W = 32;
    localparam int FRAME_W  = 32;
    localparam int LOST_W   = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd13888889;

    typedef enum logic [OP_W-1:0] {
        OP_START    = 3'd0,
        OP_SHUTDOWN = 3'd1,
        OP_BEGIN    = 3'd2,
        OP_END      = 3'd3,
        OP_EXIT     = 3'd4,
        OP_WAIT     = 3'd5,
        OP_POLL     = 3'd6
    } t_op;

endpackage

FILE: rtl/xr_session_lifecycle_fsm_top.sv
// ---------------------------------------------------------------------------
// xr_session_lifecycle_fsm_top
// session lifecycle state machine with a ring of state-change events
// ---------------------------------------------------------------------------
// A request is taken on any edge with start high (busy is always low) and
// its result appears in the result register while o_result_valid is high,
// for that one cycle only: the receiver cannot stall, so capture it then.
// Throughput is one request per cycle: the request is registered, then one
// pass of short logic against the session state and the event ring forms
// the result register. Back-to-back requests see each other's state
// changes, since the state updates in the same edge as the result.
// The event ring holds EVENT_QUEUE_DEPTH entries in flip-flops; begin
// pushes three events at once. When the ring is full the state still
// changes and the dropped events are counted in o_events_lost. The user
// writes display period via i_cfg_we / i_cfg_wdata only while idle; unenforced.
`include "assert_macros.svh"

module xr_session_lifecycle_fsm_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cfg_we,
    input  logic [xrslc_pkg::PERIOD_W-1:0]   i_cfg_wdata,
    input  logic [xrslc_pkg::OP_W-1:0]       i_operation,
    input  logic [xrslc_pkg::TIME_W-1:0]     i_now_ns,
    input  logic                             i_window_minimized,
    output logic                             o_result_valid,
    output logic                             o_accepted,
    output logic [xrslc_pkg::STATE_W-1:0]    o_session_state,
    output logic                             o_event_valid,
    output logic [xrslc_pkg::STATE_W-1:0]    o_event_state,
    output logic [xrslc_pkg::TIME_W-1:0]     o_event_time,
    output logic [xrslc_pkg::PRED_W-1:0]     o_predicted_display_time,
    output logic                             o_should_render,
    output logic [xrslc_pkg::FRAME_W-1:0]    o_frame_number,
    output logic [xrslc_pkg::LOST_W-1:0]     o_events_lost
);
    import xrslc_pkg::*;

    // session states, same code as the session_state port
    typedef enum logic [STATE_W-1:0] {
        S_IDLE     = 3'd0,
        S_READY    = 3'd1,
        S_SYNC     = 3'd2,
        S_VISIBLE  = 3'd3,
        S_FOCUSED  = 3'd4,
        S_STOPPING = 3'd5,
        S_EXITING  = 3'd6
    } t_sess;

    localparam int MAX_PUSH = 3;    // begin queues sync, visible, focused
    localparam int SUM_W    = QCNT_W + 1;

    // configuration
    logic [PERIOD_W-1:0] r_period;

    // request register
    logic                r_req_valid;
    t_op                 r_op;
    logic [TIME_W-1:0]   r_now;
    logic                r_min;

    // session and ring state
    t_sess               r_state,  n_state;
    logic [QIDX_W-1:0]   r_head,   n_head;
    logic [QCNT_W-1:0]   r_count,  n_count;
    logic [FRAME_W-1:0]  r_frames, n_frames;
    t_sess               r_ev_state [EVENT_QUEUE_DEPTH];
    logic [TIME_W-1:0]   r_ev_time  [EVENT_QUEUE_DEPTH];

    // result register
    logic                r_res_valid;
    logic                r_acc,     n_acc;
    logic                r_evv,     n_evv;
    t_sess               r_evs,     n_evs;
    logic [TIME_W-1:0]   r_evt,     n_evt;
    logic [PRED_W-1:0]   r_pred,    n_pred;
    logic                r_render,  n_render;
    logic [LOST_W-1:0]   r_lost,    n_lost;

    // push bookkeeping
    logic [1:0]          push_num;
    t_sess               push_val  [MAX_PUSH];
    logic [QCNT_W-1:0]   free_cnt;
    logic [1:0]          stored;
    logic [SUM_W-1:0]    slot_sum  [MAX_PUSH];
    logic [QIDX_W-1:0]   slot_idx  [MAX_PUSH];
    logic                slot_we   [MAX_PUSH];
    logic                running;

    // pipeline takes a request on every cycle
    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // one pass: operation decode, ring push / pop, frame timing
    // ---------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_frames = r_frames;
        n_acc    = 1'b0;
        n_evv    = 1'b0;
        n_evs    = S_IDLE;
        n_evt    = '0;
        n_pred   = '0;
        n_render = 1'b0;
        push_num = 2'd0;
        for (int k = 0; k < MAX_PUSH; k++) begin
            push_val[k] = S_IDLE;
        end
        running = (r_state == S_SYNC) || (r_state == S_VISIBLE) ||
                  (r_state == S_FOCUSED);

        if (r_req_valid) begin
            case (r_op)
                OP_START: begin
                    push_num    = 2'd1;
                    push_val[0] = S_READY;
                    n_state     = S_READY;
                    n_acc       = 1'b1;
                end
                OP_SHUTDOWN: begin
                    n_state = S_IDLE;
                    n_count = '0;
                    n_acc   = 1'b1;
                end
                OP_BEGIN: begin
                    if (r_state == S_READY) begin
                        push_num    = 2'd3;
                        push_val[0] = S_SYNC;
                        push_val[1] = S_VISIBLE;
                        push_val[2] = S_FOCUSED;
                        n_state     = S_FOCUSED;
                        n_frames    = '0;
                        n_acc       = 1'b1;
                    end
                end
                OP_END: begin
                    if (r_state == S_STOPPING) begin
                        push_num    = 2'd1;
                        push_val[0] = S_EXITING;
                        n_state     = S_EXITING;
                        n_acc       = 1'b1;
                    end
                end
                OP_EXIT: begin
                    if (running) begin
                        push_num    = 2'd1;
                        push_val[0] = S_STOPPING;
                        n_state     = S_STOPPING;
                        n_acc       = 1'b1;
                    end else if (r_state == S_IDLE || r_state == S_READY) begin
                        push_num    = 2'd1;
                        push_val[0] = S_EXITING;
                        n_state     = S_EXITING;
                        n_acc       = 1'b1;
                    end
                end
                OP_WAIT: begin
                    if (running || r_state == S_STOPPING) begin
                        n_frames = r_frames + 1'b1;
                        n_pred   = PRED_W'(r_now) + PRED_W'(r_period);
                        n_render = !r_min &&
                                   (r_state == S_VISIBLE || r_state == S_FOCUSED);
                        n_acc    = 1'b1;
                    end
                end
                OP_POLL: begin
                    if (r_count != '0) begin
                        n_evv   = 1'b1;
                        n_evs   = r_ev_state[r_head];
                        n_evt   = r_ev_time[r_head];
                        n_count = r_count - 1'b1;
                        n_acc   = 1'b1;
                        if (r_head == QIDX_W'(EVENT_QUEUE_DEPTH - 1)) begin
                            n_head = '0;
                        end else begin
                            n_head = r_head + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // pushes land behind the current tail, extras beyond the free room are lost
        free_cnt = QCNT_W'(EVENT_QUEUE_DEPTH) - r_count;
        if (QCNT_W'(push_num) < free_cnt) begin
            stored = push_num;
        end else begin
            stored = free_cnt[1:0];
        end
        n_lost = push_num - stored;
        if (push_num != 2'd0) begin
            n_count = r_count + QCNT_W'(stored);
        end
        for (int k = 0; k < MAX_PUSH; k++) begin
            slot_we[k]  = (2'(k) < stored);
            slot_sum[k] = SUM_W'(r_head) + SUM_W'(r_count) + SUM_W'(k);
            if (slot_sum[k] >= SUM_W'(EVENT_QUEUE_DEPTH)) begin
                slot_idx[k] = QIDX_W'(slot_sum[k] - SUM_W'(EVENT_QUEUE_DEPTH));
            end else begin
                slot_idx[k] = QIDX_W'(slot_sum[k]);
            end
        end
    end

    // ---------------------------------------------------------------
    // control, state and result registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RESET;
            r_req_valid <= 1'b0;
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_frames    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            r_req_valid <= start;
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_frames    <= n_frames;
            r_res_valid <= r_req_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op  <= t_op'(i_operation);
            r_now <= i_now_ns;
            r_min <= i_window_minimized;
        end
        r_acc    <= n_acc;
        r_evv    <= n_evv;
        r_evs    <= n_evs;
        r_evt    <= n_evt;
        r_pred   <= n_pred;
        r_render <= n_render;
        r_lost   <= n_lost;
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (slot_we[k]) begin
                r_ev_state[slot_idx[k]] <= push_val[k];
                r_ev_time[slot_idx[k]]  <= r_now;
            end
        end
    end

    assign o_result_valid           = r_res_valid;
    assign o_accepted               = r_acc;
    assign o_session_state          = r_state;
    assign o_event_valid            = r_evv;
    assign o_event_state            = r_evs;
    assign o_event_time             = r_evt;
    assign o_predicted_display_time = r_pred;
    assign o_should_render          = r_render;
    assign o_frame_number           = r_frames;
    assign o_events_lost            = r_lost;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n,
        r_count <= QCNT_W'(EVENT_QUEUE_DEPTH), "event ring count exceeds depth")
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n,
        r_req_valid, o_result_valid, "request produced no result strobe")
    `ASSERT_ALWAYS(a_lost_only_accepted, i_clk, i_rst_n,
        !(o_result_valid && o_events_lost != '0) || (o_accepted && !o_event_valid),
        "events lost on a rejected request or a poll")

endmodule
